// ----- sv/bpfa_pkg.sv -----
// Shared types and constants of the bitmap page-frame allocator.
package bpfa_pkg;

  localparam int Pages    = 32768;
  localparam int WordBits = 32;
  localparam int Words    = Pages / WordBits;
  localparam int AddrW    = $clog2(Words);
  localparam int BitW     = $clog2(WordBits);

  localparam logic [15:0] PagesVal    = 16'd32768;
  localparam logic [15:0] LowFirst    = 16'd32;
  localparam logic [15:0] HighFirst   = 16'd256;
  localparam logic [15:0] MemPagesRst = 16'd32768;
  localparam logic [15:0] FloorRst    = 16'd512;

  localparam logic [2:0] CmdAllocNormal = 3'd0;
  localparam logic [2:0] CmdAllocLow    = 3'd1;
  localparam logic [2:0] CmdFreePage    = 3'd2;
  localparam logic [2:0] CmdFreeRange   = 3'd3;
  localparam logic [2:0] CmdReserve     = 3'd4;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNoFree   = 2'd1;
  localparam logic [1:0] StRange    = 2'd2;
  localparam logic [1:0] StWasFree  = 2'd3;

  localparam logic [1:0] RegMemPages = 2'd0;
  localparam logic [1:0] RegFloor    = 2'd1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_FREE_RD, S_FREE_EV,
    S_RANGE_RD, S_RANGE_WR, S_RESP
  } state_t;

endpackage

// ----- sv/bitmap_page_frame_allocator_top.sv -----
// Bitmap page-frame allocator: first-fit search and range updates over a used bitmap.
// Unknown commands and ignored frees go straight to the response; a single-page free reads
// then writes its word; an allocate reads and tests each bitmap word scanned (up to 1016),
// and a range each word it touches. One command at a time; the bitmap RMW sets the rate.
// After rst a clearing pass over all 1024 words marks every page used; in_stall holds high.
module bitmap_page_frame_allocator_top import bpfa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [14:0] page_index,
  input  logic [15:0] page_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] granted_page,
  output logic [1:0]  status,
  output logic [15:0] used_pages,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [WordBits-1:0] mem [Words];
  logic [WordBits-1:0] rdata;
  logic                we;
  logic [AddrW-1:0]    waddr;
  logic [WordBits-1:0] wdata;

  state_t st, st_next;
  logic [AddrW-1:0] init_addr;
  logic [2:0]      cmd, cmd_next;
  logic [15:0]     cur, cur_next;
  logic [15:0]     rem, rem_next;
  logic [15:0]     hi, hi_next;
  logic [15:0]     cnt, cnt_next;
  logic [14:0]     res_page, res_page_next;
  logic [1:0]      res_st, res_st_next;
  logic [15:0]     mem_pages, floor_page;

  logic [WordBits-1:0] lim, avail, mask;
  logic [BitW-1:0]     low_bit;
  logic [5:0]          span, n;
  logic [16:0]         sum;
  logic                load_out;

  assign cfg_ready = 1'b1;
  assign in_stall  = (st != S_IDLE);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[cur[14:5]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_pages  <= MemPagesRst;
      floor_page <= FloorRst;
    end else if (cfg_valid) begin
      if (cfg_index == RegMemPages) mem_pages <= cfg_data;
      else if (cfg_index == RegFloor) floor_page <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_INIT;
      init_addr <= '0;
      cnt       <= PagesVal;
      out_valid <= 1'b0;
    end else begin
      st  <= st_next;
      cnt <= cnt_next;
      if (st == S_INIT) init_addr <= init_addr + 1'b1;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    cur      <= cur_next;
    rem      <= rem_next;
    hi       <= hi_next;
    res_page <= res_page_next;
    res_st   <= res_st_next;
    if (load_out) begin
      granted_page <= res_page;
      status       <= res_st;
      used_pages   <= cnt;
    end
  end

  always_comb begin
    for (int b = 0; b < WordBits; b++)
      lim[b] = ({cur[15:5], b[BitW-1:0]} < hi);
    avail   = ~rdata & lim;
    low_bit = '0;
    for (int b = WordBits - 1; b >= 0; b--)
      if (avail[b]) low_bit = b[BitW-1:0];
    span = 6'(WordBits) - {1'b0, cur[4:0]};
    n    = (rem < {10'd0, span}) ? rem[5:0] : span;
    for (int b = 0; b < WordBits; b++)
      mask[b] = (b[5:0] >= {1'b0, cur[4:0]}) && ({1'b0, b[5:0]} < {1'b0, cur[4:0]} + n);
    sum = {1'b0, cnt} + {11'd0, n};
  end

  always_comb begin
    st_next       = st;
    cmd_next      = cmd;
    cur_next      = cur;
    rem_next      = rem;
    hi_next       = hi;
    cnt_next      = cnt;
    res_page_next = res_page;
    res_st_next   = res_st;
    we            = 1'b0;
    waddr         = cur[14:5];
    wdata         = rdata;
    load_out      = 1'b0;
    case (st)
      S_INIT: begin
        we    = 1'b1;
        waddr = init_addr;
        wdata = '1;
        if (init_addr == AddrW'(Words - 1)) st_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_next      = command;
          res_page_next = '0;
          res_st_next   = StOk;
          cur_next      = {1'b0, page_index};
          rem_next      = page_count;
          case (command)
            CmdAllocNormal: begin
              cur_next = HighFirst;
              hi_next  = (mem_pages > PagesVal) ? PagesVal : mem_pages;
              st_next  = S_SCAN_RD;
            end
            CmdAllocLow: begin
              cur_next = LowFirst;
              hi_next  = HighFirst;
              st_next  = S_SCAN_RD;
            end
            CmdFreePage: begin
              if ({1'b0, page_index} < floor_page || {1'b0, page_index} >= mem_pages) begin
                res_st_next = StRange;
                st_next     = S_RESP;
              end else begin
                st_next = S_FREE_RD;
              end
            end
            CmdFreeRange, CmdReserve: st_next = S_RANGE_RD;
            default: st_next = S_RESP;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (cur >= hi) begin
          res_st_next = StNoFree;
          st_next     = S_RESP;
        end else begin
          st_next = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (avail != '0) begin
          we            = 1'b1;
          wdata         = rdata | (WordBits'(1) << low_bit);
          res_page_next = {cur[14:5], low_bit};
          if (cnt < PagesVal) cnt_next = cnt + 16'd1;
          st_next = S_RESP;
        end else begin
          cur_next = cur + 16'(WordBits);
          st_next  = S_SCAN_RD;
        end
      end
      S_FREE_RD: st_next = S_FREE_EV;
      S_FREE_EV: begin
        if (!rdata[cur[4:0]]) begin
          res_st_next = StWasFree;
        end else begin
          we    = 1'b1;
          wdata = rdata & ~(WordBits'(1) << cur[4:0]);
          if (cnt != '0) cnt_next = cnt - 16'd1;
        end
        st_next = S_RESP;
      end
      S_RANGE_RD: begin
        if (rem == '0 || cur[15]) st_next = S_RESP;
        else st_next = S_RANGE_WR;
      end
      S_RANGE_WR: begin
        we = 1'b1;
        if (cmd == CmdReserve) begin
          wdata    = rdata | mask;
          cnt_next = (sum > {1'b0, PagesVal}) ? PagesVal : sum[15:0];
        end else begin
          wdata    = rdata & ~mask;
          cnt_next = (cnt < {10'd0, n}) ? 16'd0 : cnt - {10'd0, n};
        end
        cur_next = cur + {10'd0, n};
        rem_next = rem - {10'd0, n};
        st_next  = S_RANGE_RD;
      end
      S_RESP: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          load_out = 1'b1;
          st_next  = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (rst) cnt <= PagesVal)
    else $error("used count above page total");
  a_init_stall: assert property (@(posedge clk) disable iff (rst)
    st == S_INIT |-> in_stall && !load_out)
    else $error("request taken during clearing pass");
  a_range_step: assert property (@(posedge clk) disable iff (rst)
    st == S_RANGE_WR |=> rem < $past(rem))
    else $error("range walk made no progress");

endmodule
